@@ rtl/cmta_pkg.sv @@
// shared constants, types and face codes for the cube map texel address unit
package cmta_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int TEXEL_BITS     = 12;
    localparam int REG_BITS       = 13;

    localparam int MAG_BITS  = COMPONENT_BITS;
    localparam int BASE_BITS = COMPONENT_BITS + 1;
    localparam int DEN_BITS  = COMPONENT_BITS + 1;
    localparam int SIZE_BITS = TEXEL_BITS + 1;
    localparam int QUO_BITS  = TEXEL_BITS + 1;
    localparam int NUM_BITS  = BASE_BITS + SIZE_BITS;

    localparam int FACE_BITS   = 3;
    localparam int S_DATA_BITS = ((3 * COMPONENT_BITS) + 7) / 8 * 8;
    localparam int M_DATA_BITS = ((FACE_BITS + 2 * TEXEL_BITS) + 7) / 8 * 8;

    localparam logic [REG_BITS-1:0] SIZE_RESET = REG_BITS'(512);

    typedef enum logic [0:0] {
        REG_FACE_WIDTH  = 1'b0,
        REG_FACE_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [FACE_BITS-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    typedef struct packed {
        logic [BASE_BITS-1:0] base_x;
        logic [BASE_BITS-1:0] base_y;
        logic [DEN_BITS-1:0]  den;
        face_t                face;
        logic                 zero;
    } sel_data_t;

    typedef struct packed {
        logic [DEN_BITS-1:0] rem;
        logic [QUO_BITS-1:0] rest;
        logic [QUO_BITS-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t           lane_x;
        div_lane_t           lane_y;
        logic [DEN_BITS-1:0] den;
        face_t               face;
        logic                zero;
    } cell_data_t;

endpackage

@@ rtl/cmta_face_sel.sv @@
// major axis pick, face code and offset face coordinates, one register stage
module cmta_face_sel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0] dir_x,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0] dir_y,
    input  logic [cmta_pkg::COMPONENT_BITS-1:0] dir_z,
    output logic                              out_valid,
    output cmta_pkg::sel_data_t               out_data
);
    import cmta_pkg::*;

    localparam int C = COMPONENT_BITS;

    logic [C:0]          xe, ye, ze;
    logic [C:0]          xa, ya, za;
    logic [MAG_BITS-1:0] ax, ay, az;
    logic [MAG_BITS-1:0] ma;
    logic [C:0]          sc, tc;
    logic [C+1:0]        sum_s, sum_t;
    face_t               face;
    logic                z_pos;
    logic                valid_reg;
    sel_data_t           data_reg, data_next;

    assign xe = {dir_x[C-1], dir_x};
    assign ye = {dir_y[C-1], dir_y};
    assign ze = {dir_z[C-1], dir_z};
    assign xa = dir_x[C-1] ? (~xe + 1'b1) : xe;
    assign ya = dir_y[C-1] ? (~ye + 1'b1) : ye;
    assign za = dir_z[C-1] ? (~ze + 1'b1) : ze;
    assign ax = xa[MAG_BITS-1:0];
    assign ay = ya[MAG_BITS-1:0];
    assign az = za[MAG_BITS-1:0];
    assign z_pos = !dir_z[C-1] && (dir_z != '0);

    always_comb
    begin
        priority if ((ax > ay) && (ax > az))
        begin
            ma = ax;
            tc = ye;
            if (!dir_x[C-1])
            begin
                face = FACE_POS_X;
                sc   = ze;
            end
            else
            begin
                face = FACE_NEG_X;
                sc   = ~ze + 1'b1;
            end
        end
        else if (ay > az)
        begin
            ma = ay;
            sc = xe;
            if (!dir_y[C-1])
            begin
                face = FACE_POS_Y;
                tc   = ze;
            end
            else
            begin
                face = FACE_NEG_Y;
                tc   = ~ze + 1'b1;
            end
        end
        else
        begin
            ma = az;
            tc = ye;
            if (z_pos)
            begin
                face = FACE_POS_Z;
                sc   = ~xe + 1'b1;
            end
            else
            begin
                face = FACE_NEG_Z;
                sc   = xe;
            end
        end
    end

    assign sum_s = {sc[C], sc} + {2'b00, ma};
    assign sum_t = {tc[C], tc} + {2'b00, ma};

    always_comb
    begin
        data_next.base_x = sum_s[BASE_BITS-1:0];
        data_next.base_y = sum_t[BASE_BITS-1:0];
        data_next.den    = {ma, 1'b0};
        data_next.face   = face;
        data_next.zero   = (ma == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/cmta_scale.sv @@
// scales both offset coordinates by the face size and seeds the divider lanes
module cmta_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  cmta_pkg::sel_data_t          in_data,
    input  logic [cmta_pkg::SIZE_BITS-1:0] size_w,
    input  logic [cmta_pkg::SIZE_BITS-1:0] size_h,
    output logic                         out_valid,
    output cmta_pkg::cell_data_t         out_data
);
    import cmta_pkg::*;

    logic [NUM_BITS-1:0] num_x, num_y;
    logic                valid_reg;
    cell_data_t          data_reg, data_next;

    assign num_x = NUM_BITS'(in_data.base_x) * NUM_BITS'(size_w);
    assign num_y = NUM_BITS'(in_data.base_y) * NUM_BITS'(size_h);

    always_comb
    begin
        data_next.lane_x.rem  = num_x[NUM_BITS-1 -: DEN_BITS];
        data_next.lane_x.rest = num_x[QUO_BITS-1:0];
        data_next.lane_x.quo  = '0;
        data_next.lane_y.rem  = num_y[NUM_BITS-1 -: DEN_BITS];
        data_next.lane_y.rest = num_y[QUO_BITS-1:0];
        data_next.lane_y.quo  = '0;
        data_next.den         = in_data.den;
        data_next.face        = in_data.face;
        data_next.zero        = in_data.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/cmta_div_cell.sv @@
// one restoring divide cell: one quotient bit for each of the two lanes
module cmta_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cmta_pkg::cell_data_t in_data,
    output logic                 out_valid,
    output cmta_pkg::cell_data_t out_data
);
    import cmta_pkg::*;

    logic       valid_reg;
    cell_data_t data_reg, data_next;

    function automatic div_lane_t lane_step(input div_lane_t l, input logic [DEN_BITS-1:0] d);
        logic [DEN_BITS:0] t;
        div_lane_t         r;
        t = {l.rem, l.rest[QUO_BITS-1]};
        r = l;
        if (t >= {1'b0, d})
        begin
            t     = t - {1'b0, d};
            r.quo = {l.quo[QUO_BITS-2:0], 1'b1};
        end
        else
        begin
            r.quo = {l.quo[QUO_BITS-2:0], 1'b0};
        end
        r.rem  = t[DEN_BITS-1:0];
        r.rest = {l.rest[QUO_BITS-2:0], 1'b0};
        return r;
    endfunction

    always_comb
    begin
        data_next        = in_data;
        data_next.lane_x = lane_step(in_data.lane_x, in_data.den);
        data_next.lane_y = lane_step(in_data.lane_y, in_data.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/cube_map_texel_address_unit.sv @@
// cube map texel address unit: face select, scale, divider cell chain, output register
// stages from input request to result: select, scale, 13 divide cells, output
// throughput: one request per cycle while the output is not stalled, one quotient bit per divide cell per cycle
// each stage holds its request while the next is full, bubbles fill behind a stalled result
// reset clears all stage valid flags and sets face_width and face_height to 512
module cube_map_texel_address_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // dir_x, dir_y, dir_z
    input  logic [cmta_pkg::S_DATA_BITS-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // face, texel_x, texel_y
    output logic [cmta_pkg::M_DATA_BITS-1:0]  m_axis_tdata,
    // zero_direction
    output logic [0:0]                        m_axis_tuser
);
    import cmta_pkg::*;

    localparam int C = COMPONENT_BITS;
    localparam int T = TEXEL_BITS;

    logic [REG_BITS-1:0]  face_width_reg, face_height_reg;
    logic [SIZE_BITS-1:0] size_w, size_h;
    reg_index_t           wr_index;

    logic                 sel_valid;
    sel_data_t            sel_data;
    logic [QUO_BITS:0]    cell_valid;
    cell_data_t           cell_data [QUO_BITS+1];
    logic [QUO_BITS-1:0]  cell_en;
    logic                 en_sel, en_scale, en_out;

    logic                    m_valid_reg;
    logic [M_DATA_BITS-1:0]  m_data_reg, m_data_next;
    logic [0:0]              m_user_reg;
    logic [QUO_BITS-1:0]     tx_q, ty_q;
    logic [T-1:0]            tx, ty;
    cell_data_t              last;

    // configuration registers
    assign pready   = 1'b1;
    assign wr_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_width_reg  <= SIZE_RESET;
            face_height_reg <= SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (wr_index)
                REG_FACE_WIDTH:  face_width_reg  <= pwdata[REG_BITS-1:0];
                REG_FACE_HEIGHT: face_height_reg <= pwdata[REG_BITS-1:0];
                default:         face_width_reg  <= face_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_index)
            REG_FACE_WIDTH:  prdata = 32'(face_width_reg);
            REG_FACE_HEIGHT: prdata = 32'(face_height_reg);
            default:         prdata = '0;
        endcase
    end

    // sizes above the texel range saturate
    assign size_w = (32'(face_width_reg) > (32'd1 << T)) ? SIZE_BITS'(32'd1 << T)
                                                         : SIZE_BITS'(face_width_reg);
    assign size_h = (32'(face_height_reg) > (32'd1 << T)) ? SIZE_BITS'(32'd1 << T)
                                                          : SIZE_BITS'(face_height_reg);

    // stage enables, a stage loads when empty or when its successor loads
    assign en_out   = !m_valid_reg || m_axis_tready;
    assign en_scale = !cell_valid[0] || cell_en[0];
    assign en_sel   = !sel_valid || en_scale;
    assign s_axis_tready = en_sel;

    genvar k;
    generate
        for (k = 0; k < QUO_BITS; k++)
        begin : g_en
            if (k == QUO_BITS - 1)
            begin : g_last
                assign cell_en[k] = !cell_valid[k+1] || en_out;
            end
            else
            begin : g_mid
                assign cell_en[k] = !cell_valid[k+1] || cell_en[k+1];
            end
        end
    endgenerate

    cmta_face_sel u_face_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_sel),
        .in_valid  (s_axis_tvalid),
        .dir_x     (s_axis_tdata[C-1:0]),
        .dir_y     (s_axis_tdata[2*C-1:C]),
        .dir_z     (s_axis_tdata[3*C-1:2*C]),
        .out_valid (sel_valid),
        .out_data  (sel_data)
    );

    cmta_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_scale),
        .in_valid  (sel_valid),
        .in_data   (sel_data),
        .size_w    (size_w),
        .size_h    (size_h),
        .out_valid (cell_valid[0]),
        .out_data  (cell_data[0])
    );

    generate
        for (k = 0; k < QUO_BITS; k++)
        begin : g_cell
            cmta_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (cell_en[k]),
                .in_valid  (cell_valid[k]),
                .in_data   (cell_data[k]),
                .out_valid (cell_valid[k+1]),
                .out_data  (cell_data[k+1])
            );
        end
    endgenerate

    // edge wrap and zero vector forcing
    assign last = cell_data[QUO_BITS];
    assign tx_q = (last.zero || (last.lane_x.quo >= size_w)) ? '0 : last.lane_x.quo;
    assign ty_q = (last.zero || (last.lane_y.quo >= size_h)) ? '0 : last.lane_y.quo;
    assign tx   = tx_q[T-1:0];
    assign ty   = ty_q[T-1:0];

    always_comb
    begin
        m_data_next = '0;
        m_data_next[FACE_BITS-1:0]                     = last.face;
        m_data_next[FACE_BITS+T-1:FACE_BITS]           = tx;
        m_data_next[FACE_BITS+2*T-1:FACE_BITS+T]       = ty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            m_valid_reg <= cell_valid[QUO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= last.zero;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTH
    // zero vector result carries the -z face and texel zero
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        ((m_axis_tdata[FACE_BITS-1:0] == FACE_NEG_Z) &&
         (m_axis_tdata[FACE_BITS+2*T-1:FACE_BITS] == '0)))
        else $error("zero direction result with nonzero face or texel");

    // a result never carries a face code beyond the six faces
    a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FACE_BITS-1:0] <= FACE_NEG_Z))
        else $error("result face code out of range");

    // with the output register empty the whole chain must be able to take a request
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");
`endif

endmodule
